>>> src/ttsat_pkg.sv
package ttsat_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int VPN_W       = 20;
    localparam int TEN_W       = 4;
    localparam int PPN_W       = 32;
    localparam int AGE_W       = 64;
    localparam int HASH_W      = 32;
    localparam int LFSR_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU     = 2'd2;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_DSETS_GO,
        ST_DSETS_WAIT,
        ST_DSET_GO,
        ST_DSET_WAIT,
        ST_BASE,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_DVIC_GO,
        ST_DVIC_WAIT,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_SETS,
        DIV_SET,
        DIV_VIC
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    calc_hash;
        logic    div_start;
        div_op_t div_op;
        logic    take_sets;
        logic    take_set;
        logic    take_vic;
        logic    calc_base;
        logic    rd_way;
        logic    scan_way;
        logic    step_lfsr;
        logic    wr_entry;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic is_fill;
        logic div_done;
        logic scan_hit;
        logic scan_last;
        logic victim_found;
        logic lru;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [VPN_W-1:0] vpn;
        logic [TEN_W-1:0] ten;
        logic [PPN_W-1:0] ppn;
    } tag_t;

    // Fibonacci LFSR, taps 16,14,13,11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

>>> src/ttsat_div.sv
module ttsat_div
    import ttsat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [HASH_W-1:0]     num,
    input  logic [CFG_DATA_W-1:0] den,
    output logic                  done,
    output logic [HASH_W-1:0]     quot,
    output logic [CFG_DATA_W-1:0] rem
);

    localparam int STEP_W = $clog2(HASH_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [STEP_W-1:0]     step_reg,  step_next;
    logic [HASH_W-1:0]     q_reg,     q_next;
    logic [CFG_DATA_W-1:0] r_reg,     r_next;
    logic [CFG_DATA_W-1:0] d_reg,     d_next;
    logic [CFG_DATA_W:0]   trial;

    // one restoring step per cycle, numerator shifts out as quotient shifts in
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[HASH_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            q_next    = num;
            r_next    = '0;
            d_next    = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = CFG_DATA_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[HASH_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[CFG_DATA_W-1:0];
                q_next = {q_reg[HASH_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

>>> src/ttsat_ctrl.sv
module ttsat_ctrl
    import ttsat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_HASH;
            ST_HASH:       state_next = ST_DSETS_GO;
            ST_DSETS_GO:   state_next = ST_DSETS_WAIT;
            ST_DSETS_WAIT: if (sts.div_done) state_next = ST_DSET_GO;
            ST_DSET_GO:    state_next = ST_DSET_WAIT;
            ST_DSET_WAIT:  if (sts.div_done) state_next = ST_BASE;
            ST_BASE:       state_next = ST_READ;
            ST_READ:       state_next = ST_CMP;
            ST_CMP:
            begin
                priority if (sts.scan_hit)  state_next = ST_DONE;
                else if (sts.scan_last)     state_next = sts.is_fill ? ST_DECIDE : ST_DONE;
                else                        state_next = ST_READ;
            end
            ST_DECIDE:
                state_next = (sts.victim_found || sts.lru) ? ST_WRITE : ST_DVIC_GO;
            ST_DVIC_GO:    state_next = ST_DVIC_WAIT;
            ST_DVIC_WAIT:  if (sts.div_done) state_next = ST_WRITE;
            ST_WRITE:      state_next = ST_DONE;
            ST_DONE:       if (sts.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.div_op = DIV_SETS;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_HASH:       cmd.calc_hash = 1'b1;
            ST_DSETS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SETS;
            end
            ST_DSETS_WAIT: cmd.take_sets = sts.div_done;
            ST_DSET_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SET;
            end
            ST_DSET_WAIT:  cmd.take_set = sts.div_done;
            ST_BASE:       cmd.calc_base = 1'b1;
            ST_READ:       cmd.rd_way = 1'b1;
            ST_CMP:        cmd.scan_way = 1'b1;
            ST_DECIDE:     cmd.step_lfsr = !(sts.victim_found || sts.lru);
            ST_DVIC_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_VIC;
            end
            ST_DVIC_WAIT:  cmd.take_vic = sts.div_done;
            ST_WRITE:      cmd.wr_entry = 1'b1;
            ST_DONE:       cmd.load_out = sts.out_free;
            default:       cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/ttsat_dp.sv
module ttsat_dp
    import ttsat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  func,
    input  logic [VPN_W-1:0]      virt_page,
    input  logic [TEN_W-1:0]      tenant,
    input  logic [PPN_W-1:0]      fill_ppn,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [PPN_W-1:0]      phys_page
);

    // configuration
    logic [CFG_DATA_W-1:0] entries_reg, ways_reg;
    logic                  lru_reg;

    // item and scan state
    logic                  func_reg;
    logic [VPN_W-1:0]      vpn_reg;
    logic [TEN_W-1:0]      ten_reg;
    logic [PPN_W-1:0]      ppn_reg;
    logic [AGE_W-1:0]      count_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [HASH_W-1:0]     prod_reg;
    logic [CFG_DATA_W-1:0] sets_reg;
    logic [IDX_W-1:0]      set_reg, base_reg, way_reg, victim_reg;
    logic                  found_reg, hit_reg;
    logic [AGE_W-1:0]      min_reg;
    logic [PPN_W-1:0]      hit_ppn_reg;
    logic                  out_valid_reg, out_hit_reg;
    logic [PPN_W-1:0]      out_ppn_reg;

    // storage
    tag_t                  tag_mem [MAX_ENTRIES];
    logic [AGE_W-1:0]      age_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    tag_t                  tag_q_reg;
    logic [AGE_W-1:0]      age_q_reg;
    logic                  valid_q_reg;

    logic [CFG_DATA_W-1:0] ways_eff, entries_eff;
    logic [HASH_W-1:0]     div_num;
    logic [CFG_DATA_W-1:0] div_den;
    logic                  div_done;
    logic [HASH_W-1:0]     div_quot;
    logic [CFG_DATA_W-1:0] div_rem;
    logic [IDX_W-1:0]      rd_idx, wr_idx;
    logic                  match, hit_now;
    logic [VPN_W:0]        hash_sum;

    // clamp geometry
    always_comb
    begin
        priority if (ways_reg == '0)
            ways_eff = CFG_DATA_W'(1);
        else if (ways_reg > CFG_DATA_W'(MAX_ENTRIES))
            ways_eff = CFG_DATA_W'(MAX_ENTRIES);
        else
            ways_eff = ways_reg;
        entries_eff = (entries_reg > CFG_DATA_W'(MAX_ENTRIES)) ?
                      CFG_DATA_W'(MAX_ENTRIES) : entries_reg;
    end

    // divider operand select
    always_comb
    begin
        unique case (cmd.div_op)
            DIV_SETS:
            begin
                div_num = HASH_W'(entries_eff);
                div_den = ways_eff;
            end
            DIV_SET:
            begin
                div_num = prod_reg;
                div_den = sets_reg;
            end
            DIV_VIC:
            begin
                div_num = HASH_W'(lfsr_reg);
                div_den = ways_eff;
            end
            default:
            begin
                div_num = prod_reg;
                div_den = ways_eff;
            end
        endcase
    end

    ttsat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign hash_sum = {1'b0, vpn_reg} + (VPN_W + 1)'(ten_reg);
    assign rd_idx   = base_reg + way_reg;
    assign wr_idx   = cmd.wr_entry ? (base_reg + victim_reg) : rd_idx;
    assign match    = valid_q_reg && (tag_q_reg.vpn == vpn_reg) && (tag_q_reg.ten == ten_reg);
    assign hit_now  = cmd.scan_way && (func_reg == FUNC_LOOKUP) && match;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CFG_DATA_W'(64);
            ways_reg    <= CFG_DATA_W'(4);
            lru_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENTRIES: entries_reg <= cfg_data;
                CFG_WAYS:    ways_reg    <= cfg_data;
                CFG_LRU:     lru_reg     <= cfg_data[0];
                default:     lru_reg     <= lru_reg;
            endcase
        end
    end

    // control-side state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
                count_reg <= count_reg + AGE_W'(1);
            if (cmd.step_lfsr)
                lfsr_reg <= lfsr_next(lfsr_reg);
            if (cmd.wr_entry)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func;
            vpn_reg   <= virt_page;
            ten_reg   <= tenant;
            ppn_reg   <= fill_ppn;
            way_reg   <= '0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        if (cmd.calc_hash)
            prod_reg <= HASH_W'(HASH_W'(hash_sum) * HASH_MULT);
        if (cmd.take_sets)
            sets_reg <= (div_quot[CFG_DATA_W-1:0] == '0) ? CFG_DATA_W'(1)
                                                         : div_quot[CFG_DATA_W-1:0];
        if (cmd.take_set)
            set_reg <= div_rem[IDX_W-1:0];
        if (cmd.calc_base)
            base_reg <= IDX_W'(set_reg * ways_eff);
        if (cmd.rd_way)
        begin
            tag_q_reg   <= tag_mem[rd_idx];
            age_q_reg   <= age_mem[rd_idx];
            valid_q_reg <= valid_reg[rd_idx];
        end
        // scan: first invalid way, else oldest stamp (first on tie)
        if (cmd.scan_way)
        begin
            way_reg <= way_reg + IDX_W'(1);
            if (hit_now)
            begin
                hit_reg     <= 1'b1;
                hit_ppn_reg <= tag_q_reg.ppn;
            end
            if (func_reg == FUNC_FILL && !found_reg)
            begin
                if (!valid_q_reg)
                begin
                    found_reg  <= 1'b1;
                    victim_reg <= way_reg;
                end
                else if (way_reg == '0 || age_q_reg < min_reg)
                begin
                    min_reg    <= age_q_reg;
                    victim_reg <= way_reg;
                end
            end
        end
        if (cmd.take_vic)
            victim_reg <= div_rem[IDX_W-1:0];
        if (cmd.load_out)
        begin
            out_hit_reg <= hit_reg;
            out_ppn_reg <= hit_reg ? hit_ppn_reg : '0;
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
            tag_mem[wr_idx] <= '{vpn: vpn_reg, ten: ten_reg, ppn: ppn_reg};
        if (cmd.wr_entry || hit_now)
            age_mem[wr_idx] <= count_reg;
    end

    always_comb
    begin
        sts.is_fill      = (func_reg == FUNC_FILL);
        sts.div_done     = div_done;
        sts.scan_hit     = hit_now;
        sts.scan_last    = ({1'b0, way_reg} == (ways_eff - CFG_DATA_W'(1)));
        sts.victim_found = found_reg;
        sts.lru          = lru_reg;
        sts.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign phys_page = out_ppn_reg;

endmodule

>>> src/tenant_tagged_set_assoc_tlb_core.sv
// Sequence per lookup from acceptance back to idle: two divider passes for the set count
//   and set index, then a way read and compare per way scanned; a lookup hit ends the
//   scan early; a fill adds decide and write steps, random-mode eviction another divider pass.
// Throughput: one item at a time; the shared serial divider and way scan set it.
// Reset: asynchronous, active low; clears valid bits, access counter, LFSR to 0xACE1
//   and registers to 64 entries, 4 ways, LRU. No clearing pass is needed.
module tenant_tagged_set_assoc_tlb_core
    import ttsat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [VPN_W-1:0]      virt_page,
    input  logic [TEN_W-1:0]      tenant,
    input  logic [PPN_W-1:0]      fill_ppn,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [PPN_W-1:0]      phys_page,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ttsat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttsat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .virt_page (virt_page),
        .tenant    (tenant),
        .fill_ppn  (fill_ppn),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .phys_page (phys_page)
    );

endmodule
